// ----- rtl/brb_pkg.sv -----
// Shared constants, command codes and types for the byte ring buffer peek read unit.
package brb_pkg;

    localparam int BUFFER_BYTES = 256;
    localparam int IDX_W        = $clog2(BUFFER_BYTES);
    localparam int PTR_W        = IDX_W + 1;
    localparam int FILL_W       = PTR_W;
    localparam int VALUE_W      = 32;

    localparam logic [1:0] CMD_APPEND = 2'd0;
    localparam logic [1:0] CMD_READ   = 2'd1;
    localparam logic [1:0] CMD_CLEAR  = 2'd2;

    localparam logic [1:0] WC_BYTE = 2'd0;
    localparam logic [1:0] WC_HALF = 2'd1;

    typedef struct packed {
        logic [1:0] command;
        logic [7:0] data_byte;
        logic [7:0] peek_offset;
        logic [1:0] width_code;
        logic       consume;
        logic       sign_extend;
    } req_t;

    typedef struct packed {
        logic [VALUE_W-1:0] read_value;
        logic [FILL_W-1:0]  fill_count;
        logic               is_full;
        logic               is_empty;
        logic               overflow;
    } rsp_t;

    typedef struct packed {
        logic load;
        logic issue;
        logic finish;
    } ctrl_cmd_t;

    typedef struct packed {
        logic req_read;
        logic last_byte;
        logic out_free;
    } dp_status_t;

endpackage

// ----- rtl/brb_if.sv -----
// Request and response channel interfaces with valid/ready handshake.
interface brb_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] command;
    logic [7:0] data_byte;
    logic [7:0] peek_offset;
    logic [1:0] width_code;
    logic       consume;
    logic       sign_extend;

    modport source (output valid, command, data_byte, peek_offset, width_code, consume,
                    sign_extend, input ready);
    modport sink (input valid, command, data_byte, peek_offset, width_code, consume,
                  sign_extend, output ready);
endinterface

interface brb_rsp_if;
    logic                             valid;
    logic                             ready;
    logic [brb_pkg::VALUE_W-1:0]      read_value;
    logic [brb_pkg::FILL_W-1:0]       fill_count;
    logic                             is_full;
    logic                             is_empty;
    logic                             overflow;

    modport source (output valid, read_value, fill_count, is_full, is_empty, overflow,
                    input ready);
    modport sink (input valid, read_value, fill_count, is_full, is_empty, overflow,
                  output ready);
endinterface

// ----- rtl/brb_ctrl.sv -----
// Controller state machine sequencing transfer acceptance, byte reads and result loading.
module brb_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req_valid,
    output logic                  req_ready,
    input  brb_pkg::dp_status_t   status,
    output brb_pkg::ctrl_cmd_t    cmd
);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_READ   = 4'b0010,
        ST_DRAIN  = 4'b0100,
        ST_FINISH = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        req_ready  = 1'b0;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = status.req_read ? ST_READ : ST_FINISH;
                end
            end
            ST_READ:
            begin
                cmd.issue = 1'b1;
                if (status.last_byte)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (status.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

`ifndef SYNTH
    a_finish_needs_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> status.out_free)
        else $error("result loaded while output register occupied");
    a_load_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> (state_reg == ST_READ || state_reg == ST_FINISH))
        else $error("accepted transfer did not start work");
`endif

endmodule

// ----- rtl/brb_datapath.sv -----
// Datapath: byte store, pointers, byte assembly and output register.
module brb_datapath (
    input  logic                  clk,
    input  logic                  rst_n,
    input  brb_pkg::req_t         req,
    input  brb_pkg::ctrl_cmd_t    cmd,
    output brb_pkg::dp_status_t   status,
    output brb_pkg::rsp_t         rsp,
    output logic                  rsp_valid,
    input  logic                  rsp_ready
);

    localparam int IDX_W = brb_pkg::IDX_W;
    localparam int PTR_W = brb_pkg::PTR_W;

    logic [7:0]              mem [brb_pkg::BUFFER_BYTES];
    logic [brb_pkg::BUFFER_BYTES-1:0] vld_reg;
    logic [7:0]              mem_q_reg;
    logic                    vld_q_reg;

    logic [PTR_W-1:0]        wp_reg, wp_next;
    logic [PTR_W-1:0]        rp_reg, rp_next;
    logic [1:0]              cmd_reg;
    logic [7:0]              data_reg;
    logic [IDX_W-1:0]        base_reg;
    logic [1:0]              wcode_reg;
    logic                    consume_reg;
    logic                    sext_reg;
    logic [1:0]              byte_idx_reg;
    logic                    pend_reg;
    logic [31:0]             acc_reg;

    logic                    out_valid_reg;
    brb_pkg::rsp_t           out_reg;

    logic [IDX_W-1:0]        rd_addr;
    logic [1:0]              last_idx;
    logic [PTR_W-1:0]        held;
    logic                    full_now;
    logic [PTR_W-1:0]        nbytes;
    logic [PTR_W-1:0]        step;
    logic                    do_write;
    logic                    drop;
    logic [PTR_W-1:0]        fill_next;
    logic [31:0]             value;

    assign rd_addr  = base_reg + IDX_W'(byte_idx_reg);
    assign last_idx = (wcode_reg == brb_pkg::WC_BYTE) ? 2'd0 :
                      (wcode_reg == brb_pkg::WC_HALF) ? 2'd1 : 2'd3;

    assign status.req_read  = (req.command == brb_pkg::CMD_READ);
    assign status.last_byte = (byte_idx_reg == last_idx);
    assign status.out_free  = !out_valid_reg || rsp_ready;

    assign held     = wp_reg - rp_reg;
    assign full_now = (held == PTR_W'(brb_pkg::BUFFER_BYTES));
    assign nbytes   = (wcode_reg == brb_pkg::WC_BYTE) ? PTR_W'(1) :
                      (wcode_reg == brb_pkg::WC_HALF) ? PTR_W'(2) : PTR_W'(4);
    assign step     = (nbytes < held) ? nbytes : held;

    always_comb
    begin
        wp_next  = wp_reg;
        rp_next  = rp_reg;
        do_write = 1'b0;
        drop     = 1'b0;
        value    = '0;
        case (cmd_reg)
            brb_pkg::CMD_APPEND:
            begin
                if (full_now)
                begin
                    drop = 1'b1;
                end
                else
                begin
                    do_write = 1'b1;
                    wp_next  = wp_reg + PTR_W'(1);
                end
            end
            brb_pkg::CMD_READ:
            begin
                value = acc_reg;
                if (sext_reg && wcode_reg == brb_pkg::WC_BYTE && acc_reg[7])
                begin
                    value = {24'hFFFFFF, acc_reg[7:0]};
                end
                else if (sext_reg && wcode_reg == brb_pkg::WC_HALF && acc_reg[15])
                begin
                    value = {16'hFFFF, acc_reg[15:0]};
                end
                if (consume_reg)
                begin
                    rp_next = rp_reg + step;
                end
            end
            brb_pkg::CMD_CLEAR:
            begin
                wp_next = '0;
                rp_next = '0;
            end
            default:
            begin
                wp_next = wp_reg;
            end
        endcase
    end

    assign fill_next = wp_next - rp_next;

    always_ff @(posedge clk)
    begin
        if (cmd.finish && do_write)
        begin
            mem[wp_reg[IDX_W-1:0]] <= data_reg;
        end
        mem_q_reg <= mem[rd_addr];
        vld_q_reg <= vld_reg[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (cmd.finish && do_write)
        begin
            vld_reg[wp_reg[IDX_W-1:0]] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            cmd_reg     <= req.command;
            data_reg    <= req.data_byte;
            base_reg    <= rp_reg[IDX_W-1:0] + IDX_W'(req.peek_offset);
            wcode_reg   <= req.width_code;
            consume_reg <= req.consume;
            sext_reg    <= req.sign_extend;
        end
        if (cmd.load)
        begin
            acc_reg <= '0;
        end
        else if (pend_reg)
        begin
            acc_reg <= {acc_reg[23:0], (vld_q_reg ? mem_q_reg : 8'h00)};
        end
        if (cmd.finish)
        begin
            out_reg.read_value <= value;
            out_reg.fill_count <= fill_next;
            out_reg.is_full    <= (fill_next == PTR_W'(brb_pkg::BUFFER_BYTES));
            out_reg.is_empty   <= (wp_next == rp_next);
            out_reg.overflow   <= drop;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg        <= '0;
            rp_reg        <= '0;
            byte_idx_reg  <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pend_reg <= cmd.issue;
            if (cmd.load)
            begin
                byte_idx_reg <= '0;
            end
            else if (cmd.issue)
            begin
                byte_idx_reg <= byte_idx_reg + 2'd1;
            end
            if (cmd.finish)
            begin
                wp_reg        <= wp_next;
                rp_reg        <= rp_next;
                out_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign rsp       = out_reg;
    assign rsp_valid = out_valid_reg;

`ifndef SYNTH
    a_held_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        held <= PTR_W'(brb_pkg::BUFFER_BYTES))
        else $error("fill count beyond buffer size");
    a_drop_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.finish && drop) |=> (rsp_valid && rsp.is_full && $stable(wp_reg)))
        else $error("dropped append without full buffer");
    a_empty_matches_fill: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp.is_empty == (rsp.fill_count == '0)))
        else $error("empty flag disagrees with fill count");
`endif

endmodule

// ----- rtl/byte_ring_buffer_peek_read_unit.sv -----
// Top level of the byte ring buffer peek read unit.
//
// Usage: commands arrive on the req channel (append byte, read, clear) and
// each produces exactly one transfer on the rsp channel carrying the read
// value, fill count, full, empty and overflow flags after the command.
// A read assembles 1, 2 or 4 bytes big-endian from read pointer plus
// peek_offset and optionally consumes them, capped at the bytes held.
// An append to a full buffer is dropped and flagged as overflow.
// Sequencing: every command passes from idle to finish and back to idle,
// where the next is accepted; a read goes through read and drain states
// between, using the single read port of the byte store, one byte per cycle.
// The result sits in an output register, so req is accepted again while a
// result still waits; if rsp stalls, the next command runs up to its finish
// state and holds there until the output register frees.
// Reset: pointers go to zero, the store reads as zero until written, and
// no rsp transfer is pending.
module byte_ring_buffer_peek_read_unit (
    input  logic          clk,
    input  logic          rst_n,
    brb_req_if.sink       req,
    brb_rsp_if.source     rsp
);

    brb_pkg::req_t        req_payload;
    brb_pkg::rsp_t        rsp_payload;
    brb_pkg::ctrl_cmd_t   cmd;
    brb_pkg::dp_status_t  status;
    logic                 rsp_valid;

    assign req_payload.command     = req.command;
    assign req_payload.data_byte   = req.data_byte;
    assign req_payload.peek_offset = req.peek_offset;
    assign req_payload.width_code  = req.width_code;
    assign req_payload.consume     = req.consume;
    assign req_payload.sign_extend = req.sign_extend;

    brb_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .status    (status),
        .cmd       (cmd)
    );

    brb_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_payload),
        .cmd       (cmd),
        .status    (status),
        .rsp       (rsp_payload),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp.ready)
    );

    assign rsp.valid      = rsp_valid;
    assign rsp.read_value = rsp_payload.read_value;
    assign rsp.fill_count = rsp_payload.fill_count;
    assign rsp.is_full    = rsp_payload.is_full;
    assign rsp.is_empty   = rsp_payload.is_empty;
    assign rsp.overflow   = rsp_payload.overflow;

endmodule
